// File: hdl/page_replacement_fifo_lru_macros.svh
// assertion helpers for the page replacement block
`ifndef PAGE_REPLACEMENT_FIFO_LRU_MACROS_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_MACROS_SVH

// same-cycle implication, held off during reset
`define PRFL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prfl assertion failed");

// next-cycle implication, held off during reset
`define PRFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prfl assertion failed");

`endif

// File: hdl/prfl_pkg.sv
package prfl_pkg;

	localparam int FRAMES_C = 8;
	localparam int PAGES_C  = 256;

	localparam int PAGE_W  = 8;
	localparam int AGE_W   = 3;
	localparam int COUNT_W = 16;
	localparam int FIDX_W  = 3;
	localparam int CFG_W   = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [AGE_W-1:0]   AGE_OLDEST = '1;
	localparam logic [COUNT_W-1:0] FAULT_MAX  = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_USED = 1'd1;

	// policy codes
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	localparam logic [CFG_W-1:0] FRAMES_USED_RESET = 4'd8;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		logic              final_access;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [FIDX_W-1:0]  frame_index;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic [COUNT_W-1:0] fault_count;
		logic               final_res;
	} rsp_t;

	// page number folded into the page space, worked out at elaboration
	typedef logic [PAGE_W-1:0] page_tab_t [2**PAGE_W];

	function automatic page_tab_t build_page_tab();
		page_tab_t tab;
		for (int i = 0; i < 2**PAGE_W; i++) begin
			tab[i] = PAGE_W'(i % PAGES_C);
		end
		return tab;
	endfunction

	localparam page_tab_t PAGE_TAB = build_page_tab();

endpackage

// File: hdl/prfl_table.sv
module prfl_table import prfl_pkg::*; #(
	parameter int FRAMES = FRAMES_C
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             policy,
	input  logic [CFG_W-1:0] frames_used,
	input  req_t             req,
	output rsp_t             rsp
);

	localparam int FIW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic [PAGE_W-1:0]  pages_q [FRAMES];
	logic [FRAMES-1:0]  valid_q;
	logic [AGE_W-1:0]   age_q [FRAMES];
	logic [FIW-1:0]     ptr_q;
	logic [COUNT_W-1:0] total_q;

	logic [FRAMES-1:0]  valid_n;
	logic [AGE_W-1:0]   age_n [FRAMES];
	logic [FIW-1:0]     ptr_n;
	logic [COUNT_W-1:0] total_n;
	logic [FIW-1:0]     slot;
	logic [PAGE_W-1:0]  page;
	logic               found;

	always_comb begin
		int                 n;
		logic [FRAMES-1:0]  in_use;
		logic [FIW-1:0]     hit_idx;
		logic [FIW-1:0]     empty_idx;
		logic [FIW-1:0]     lru_idx;
		logic               has_empty;
		logic [AGE_W-1:0]   best;
		logic [AGE_W-1:0]   old_age;
		logic               slot_valid;
		logic [PAGE_W-1:0]  slot_page;
		logic               evict;

		page = PAGE_TAB[req.page_number];

		// frames in use, clamped to 1..FRAMES
		if (frames_used == '0) begin
			n = 1;
		end else if (int'(frames_used) > FRAMES) begin
			n = FRAMES;
		end else begin
			n = int'(frames_used);
		end
		for (int f = 0; f < FRAMES; f++) begin
			in_use[f] = (f < n);
		end

		// lowest matching frame and lowest empty frame
		found     = 1'b0;
		hit_idx   = '0;
		has_empty = 1'b0;
		empty_idx = '0;
		for (int f = FRAMES - 1; f >= 0; f--) begin
			if (in_use[f] && valid_q[f] && pages_q[f] == page) begin
				found   = 1'b1;
				hit_idx = FIW'(f);
			end
			if (in_use[f] && !valid_q[f]) begin
				has_empty = 1'b1;
				empty_idx = FIW'(f);
			end
		end

		// oldest frame, lowest index on a tie
		best    = '0;
		lru_idx = '0;
		for (int f = 0; f < FRAMES; f++) begin
			if (in_use[f] && age_q[f] > best) begin
				best    = age_q[f];
				lru_idx = FIW'(f);
			end
		end

		ptr_n = ptr_q;
		if (found) begin
			slot = hit_idx;
		end else if (policy == POLICY_LRU) begin
			slot = has_empty ? empty_idx : lru_idx;
		end else begin
			slot  = (int'(ptr_q) < n) ? ptr_q : '0;
			ptr_n = (int'(slot) + 1 >= n) ? '0 : FIW'(int'(slot) + 1);
		end

		slot_valid = 1'b0;
		slot_page  = '0;
		for (int f = 0; f < FRAMES; f++) begin
			if (FIW'(f) == slot) begin
				slot_valid = valid_q[f];
				slot_page  = pages_q[f];
			end
		end
		old_age = slot_valid ? age_q[slot] : AGE_OLDEST;
		evict   = !found && slot_valid;

		// recency update, lru only
		for (int f = 0; f < FRAMES; f++) begin
			age_n[f] = age_q[f];
			if (policy == POLICY_LRU) begin
				if (FIW'(f) == slot) begin
					age_n[f] = '0;
				end else if (in_use[f] && valid_q[f] && age_q[f] < old_age) begin
					age_n[f] = age_q[f] + 1'b1;
				end
			end
		end

		valid_n = valid_q;
		total_n = total_q;
		if (!found) begin
			for (int f = 0; f < FRAMES; f++) begin
				if (FIW'(f) == slot) begin
					valid_n[f] = 1'b1;
				end
			end
			if (total_q != FAULT_MAX) begin
				total_n = total_q + 1'b1;
			end
		end

		rsp.hit           = found;
		rsp.frame_index   = FIDX_W'(slot);
		rsp.evicted_valid = evict;
		rsp.evicted_page  = evict ? slot_page : '0;
		rsp.fault_count   = total_n;
		rsp.final_res     = req.final_access;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
			total_q <= '0;
			for (int f = 0; f < FRAMES; f++) begin
				age_q[f] <= '0;
			end
		end else if (en) begin
			if (req.final_access) begin
				valid_q <= '0;
				ptr_q   <= '0;
				total_q <= '0;
				for (int f = 0; f < FRAMES; f++) begin
					age_q[f] <= '0;
				end
			end else begin
				valid_q <= valid_n;
				ptr_q   <= ptr_n;
				total_q <= total_n;
				for (int f = 0; f < FRAMES; f++) begin
					age_q[f] <= age_n[f];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && !found) begin
			for (int f = 0; f < FRAMES; f++) begin
				if (FIW'(f) == slot) begin
					pages_q[f] <= page;
				end
			end
		end
	end

endmodule

// File: hdl/page_replacement_fifo_lru.sv
// page replacement unit, first-in first-out or least recently used. each request transaction
// carries one page reference and gives exactly one response transaction: hit flag, frame that
// now holds the page, the page evicted if any, and the running fault count (saturating at
// 65535). one reference is taken every cycle while the response side is not stalled; an
// accepted request goes to the input register, then all frames are compared, the victim
// chosen and the ages updated in one pass into the response register, which presents it.
// the stage between the registers is set by the oldest-frame search across the frames in use.
// a request flagged final_access clears valid bits, ages, fifo pointer and fault count once
// its response is formed. the user must write policy and frames_used through the cfg port
// only while no transaction is in flight; the block itself does not enforce it.
module page_replacement_fifo_lru import prfl_pkg::*; #(
	parameter int FRAMES = FRAMES_C
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	// configuration registers
	logic             policy_q;
	logic [CFG_W-1:0] frames_used_q;

	// input register
	logic req_valid_s1;
	req_t req_s1;

	// response register
	logic rsp_valid_s2;
	rsp_t rsp_s2;

	rsp_t rsp_comb;
	logic take;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= POLICY_FIFO;
			frames_used_q <= FRAMES_USED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY:      policy_q      <= cfg_data[0];
				REG_FRAMES_USED: frames_used_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// stage 1 moves on whenever the response register is free or being drained
	assign adv       = req_valid_s1 && (!rsp_valid_s2 || !rsp_stall);
	assign req_stall = req_valid_s1 && !adv;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (take) begin
			req_valid_s1 <= 1'b1;
		end else if (adv) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
	end

	// frame table: lookup, victim choice and state update in one pass
	prfl_table #(
		.FRAMES(FRAMES)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.policy     (policy_q),
		.frames_used(frames_used_q),
		.req        (req_s1),
		.rsp        (rsp_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (adv) begin
			rsp_valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

endmodule

// File: hdl/prfl_checker.sv
`include "page_replacement_fifo_lru_macros.svh"

module prfl_checker import prfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a waiting response holds its contents
	`PRFL_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// with the response register empty the request side never stalls
	`PRFL_ASSERT_NOW(a_no_stall_when_empty, clk, arst_n, !rsp_valid, !req_stall)

	// a hit never evicts
	`PRFL_ASSERT_NOW(a_hit_no_evict, clk, arst_n, rsp_valid && rsp.hit, !rsp.evicted_valid)

	// no eviction reports page zero
	`PRFL_ASSERT_NOW(a_evict_page_zero, clk, arst_n, rsp_valid && !rsp.evicted_valid, rsp.evicted_page == '0)

	// a fault is always counted
	`PRFL_ASSERT_NOW(a_fault_counted, clk, arst_n, rsp_valid && !rsp.hit, rsp.fault_count != '0)

endmodule

bind page_replacement_fifo_lru prfl_checker u_prfl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

// File: sim/page_replacement_fifo_lru_tb.sv
module page_replacement_fifo_lru_tb;
	import prfl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// generous bound: every transaction behind the heaviest receiver stall and the longest gap
	localparam int unsigned CYCLE_LIMIT = 200000;
	// references sent back to back through a single frame
	localparam int BURST_ITEMS = 24;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_EVERY_THIRD
	} stall_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;

	page_replacement_fifo_lru #(
		.FRAMES(FRAMES_C)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// shadow of the frame table, kept in step with every accepted request
	// ------------------------------------------------------------------
	logic               use_lru = POLICY_FIFO;
	logic [CFG_W-1:0]   frames_cfg = FRAMES_USED_RESET;
	logic [PAGE_W-1:0]  slot_page [FRAMES_C];
	logic               slot_live [FRAMES_C];
	logic [AGE_W-1:0]   slot_age [FRAMES_C];
	int                 load_ptr = 0;
	logic [COUNT_W-1:0] faults = '0;

	// responses still owed by the block, oldest first
	rsp_t page_outcomes [$];

	int          mismatches = 0;
	int unsigned cycles = 0;
	int          burst_left = 0;
	bit          steady_feed = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_phase = 0;
	rsp_t        want;

	initial begin
		foreach (slot_live[i]) begin
			slot_page[i] = '0;
			slot_live[i] = 1'b0;
			slot_age[i] = '0;
		end
	end

	// the touched frame becomes the youngest; anything younger than it was moves back one
	function automatic void age_touch(int slot, int n);
		logic [AGE_W-1:0] prior;
		// an empty frame counts as the oldest possible age
		prior = slot_live[slot] ? slot_age[slot] : AGE_OLDEST;
		for (int g = 0; g < n; g++) begin
			if (g != slot && slot_live[g] && slot_age[g] < prior)
				slot_age[g] = slot_age[g] + 1'b1;
		end
		slot_age[slot] = '0;
	endfunction

	// works out the response to one reference and moves the shadow table on
	function automatic rsp_t lookup_page(req_t r);
		int n;
		int slot;
		int oldest;
		logic found;
		logic empty;
		logic [PAGE_W-1:0] page;
		rsp_t o;
		page = PAGE_W'(int'(r.page_number) % PAGES_C);
		// frames_used of zero behaves as one, anything past the table as the whole table
		n = (frames_cfg == 0) ? 1 : (int'(frames_cfg) > FRAMES_C) ? FRAMES_C : int'(frames_cfg);
		found = 1'b0;
		empty = 1'b0;
		slot = 0;
		o = '0;
		for (int f = 0; f < n; f++) begin
			if (!found && slot_live[f] && slot_page[f] == page) begin
				slot = f;
				found = 1'b1;
			end
		end
		if (found) begin
			if (use_lru == POLICY_LRU)
				age_touch(slot, n);
		end else begin
			if (use_lru == POLICY_LRU) begin
				// lowest empty frame first, otherwise the oldest, lowest index on a tie
				for (int f = 0; f < n; f++) begin
					if (!empty && !slot_live[f]) begin
						slot = f;
						empty = 1'b1;
					end
				end
				if (!empty) begin
					oldest = 0;
					slot = 0;
					for (int f = 0; f < n; f++) begin
						if (int'(slot_age[f]) > oldest) begin
							oldest = int'(slot_age[f]);
							slot = f;
						end
					end
				end
				age_touch(slot, n);
			end else begin
				// a pointer left past the frames in use falls back to frame 0
				slot = (load_ptr < n) ? load_ptr : 0;
				load_ptr = (slot + 1 >= n) ? 0 : slot + 1;
			end
			if (slot_live[slot]) begin
				o.evicted_valid = 1'b1;
				o.evicted_page = slot_page[slot];
			end
			slot_page[slot] = page;
			slot_live[slot] = 1'b1;
			if (faults != FAULT_MAX)
				faults = faults + 1'b1;
		end
		o.hit = found;
		o.frame_index = FIDX_W'(slot);
		o.fault_count = faults;
		o.final_res = r.final_access;
		// a final access wipes the table once its response is formed; pages stay behind
		if (r.final_access) begin
			foreach (slot_live[i]) begin
				slot_live[i] = 1'b0;
				slot_age[i] = '0;
			end
			load_ptr = 0;
			faults = '0;
		end
		return o;
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// offers one reference, with bursts and random gaps unless feeding steadily
	task automatic send_access(input logic [PAGE_W-1:0] page, input logic fin);
		req_t item;
		int gap;
		if (!steady_feed && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		item.page_number = page;
		item.final_access = fin;
		req <= item;
		req_valid <= 1'b1;
		// hold the transaction until the block takes it
		do @(posedge clk); while (req_stall);
		page_outcomes.push_back(lookup_page(item));
	endtask

	// stops offering and waits for every owed response to come back
	task automatic wait_all_results();
		req_valid <= 1'b0;
		burst_left = 0;
		while (page_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// register writes only go in with nothing in flight
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		wait_all_results();
		cfg_index <= idx;
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POLICY)
			use_lru = value[0];
		else
			frames_cfg = value;
		@(posedge clk);
	endtask

	task automatic set_policy(input logic lru);
		write_register(REG_POLICY, CFG_W'(lru));
	endtask

	// ------------------------------------------------------------------
	// response side
	// ------------------------------------------------------------------

	// receiver stall pattern, whose character is chosen anew at random whenever its phase counter runs out
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (stall_phase == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_phase <= $urandom_range(16, 96);
		end else begin
			stall_phase <= stall_phase - 1;
		end
		case (stall_mode)
			STALL_NONE: begin
				rsp_stall <= 1'b0;
			end
			STALL_LIGHT: begin
				rsp_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_HEAVY: begin
				rsp_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				rsp_stall <= (cycles % 3 == 0);
			end
		endcase
		if (cycles == CYCLE_LIMIT) begin
			$display("page_replacement_fifo_lru test failed");
			$finish;
		end
	end

	task automatic check_field(input string what, input logic [COUNT_W-1:0] exp_v,
			input logic [COUNT_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
			mismatches++;
		end
	endtask

	// every response transaction is matched against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (page_outcomes.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %h", $time, rsp);
				mismatches++;
			end else begin
				want = page_outcomes.pop_front();
				check_field("hit", COUNT_W'(want.hit), COUNT_W'(rsp.hit));
				check_field("frame_index", COUNT_W'(want.frame_index),
					COUNT_W'(rsp.frame_index));
				check_field("evicted_valid", COUNT_W'(want.evicted_valid),
					COUNT_W'(rsp.evicted_valid));
				check_field("evicted_page", COUNT_W'(want.evicted_page),
					COUNT_W'(rsp.evicted_page));
				check_field("fault_count", want.fault_count, rsp.fault_count);
				check_field("final_res", COUNT_W'(want.final_res), COUNT_W'(rsp.final_res));
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// out of reset: first-in first-out over all eight frames, extreme page numbers
	task automatic test_reset_state();
		send_access(8'h00, 1'b0);
		send_access(8'hFF, 1'b0);
		send_access(8'h00, 1'b0);
		send_access(8'hFF, 1'b1);
	endtask

	// round-robin loading over three frames, hits leave the order alone
	task automatic test_fifo_order();
		write_register(REG_FRAMES_USED, 4'd3);
		send_access(8'd10, 1'b0);
		send_access(8'd20, 1'b0);
		send_access(8'd30, 1'b0);
		send_access(8'd20, 1'b0);
		send_access(8'd40, 1'b0);
		send_access(8'd10, 1'b0);
		send_access(8'd50, 1'b1);
	endtask

	// empty frames fill lowest first, then the least recently used goes
	task automatic test_lru_order();
		set_policy(POLICY_LRU);
		send_access(8'd1, 1'b0);
		send_access(8'd2, 1'b0);
		send_access(8'd3, 1'b0);
		send_access(8'd1, 1'b0);
		send_access(8'd4, 1'b0);
		send_access(8'd3, 1'b0);
		send_access(8'd2, 1'b1);
	endtask

	// frame counts outside the legal range, stale pointer, frames left out of use
	task automatic test_frame_limits();
		set_policy(POLICY_FIFO);
		write_register(REG_FRAMES_USED, 4'd8);
		send_access(8'd60, 1'b0);
		send_access(8'd61, 1'b0);
		send_access(8'd62, 1'b0);
		send_access(8'd63, 1'b0);
		send_access(8'd64, 1'b0);
		// pointer now sits past two frames in use
		write_register(REG_FRAMES_USED, 4'd2);
		send_access(8'd70, 1'b0);
		write_register(REG_FRAMES_USED, 4'd0);
		send_access(8'd71, 1'b0);
		// frame 4 was kept while out of use and must hit again
		write_register(REG_FRAMES_USED, 4'd15);
		send_access(8'd64, 1'b0);
		send_access(8'd72, 1'b1);
	endtask

	// one frame and alternating pages fault every time, references back to back
	task automatic test_back_to_back();
		write_register(REG_FRAMES_USED, 4'd1);
		steady_feed = 1'b1;
		for (int i = 0; i < BURST_ITEMS; i++)
			send_access(i[0] ? 8'hA5 : 8'h5A, (i == BURST_ITEMS - 1));
		steady_feed = 1'b0;
	endtask

	// random phases: mostly sequences over a small working set closed by a final access,
	// the rest loose references with random final marks
	task automatic test_random_traffic();
		logic [CFG_W-1:0] phase_frames [10];
		int done;
		int n;
		int len;
		int spread;
		logic [PAGE_W-1:0] base;
		phase_frames = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7};
		for (int phase = 0; phase < 10; phase++) begin
			set_policy(phase[0] ? POLICY_LRU : POLICY_FIFO);
			write_register(REG_FRAMES_USED, phase_frames[phase]);
			n = (phase_frames[phase] == 0) ? 1 :
				(int'(phase_frames[phase]) > FRAMES_C) ? FRAMES_C : int'(phase_frames[phase]);
			done = 0;
			while (done < 55) begin
				// in one phase, pause mid-way for the response side to empty completely
				if (phase == 4 && done >= 30 && done < 40)
					wait_all_results();
				if ($urandom_range(0, 9) < 8) begin
					len = $urandom_range(3, 30);
					spread = n + $urandom_range(0, 3);
					base = PAGE_W'($urandom_range(0, 255));
					for (int k = 0; k < len; k++)
						send_access(base + PAGE_W'($urandom_range(0, spread - 1)), (k == len - 1));
					done += len;
				end else begin
					len = $urandom_range(1, 8);
					for (int k = 0; k < len; k++)
						send_access(PAGE_W'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
					done += len;
				end
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_fifo_order();
		test_lru_order();
		test_frame_limits();
		test_back_to_back();
		test_random_traffic();

		wait_all_results();
		// let the two-stage pipe show anything stray
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("page_replacement_fifo_lru test passed");
		end else begin
			$display("page_replacement_fifo_lru test failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/prfl_pkg.sv
hdl/prfl_table.sv
hdl/page_replacement_fifo_lru.sv
hdl/prfl_checker.sv
sim/page_replacement_fifo_lru_tb.sv
